### hdl/y2nv_pkg.sv
`default_nettype none

package y2nv_pkg;

    // Field and datapath widths
    localparam int DIM_W      = 12;   // dimension registers
    localparam int STRIDE_W   = 11;   // programmed line pitch
    localparam int COORD_W    = 11;   // output coordinates
    localparam int WADDR_W    = 21;   // word_address field
    localparam int WORD_W     = 32;
    localparam int SAMPLE_W   = 8;
    localparam int NUM_W      = 2 * DIM_W;    // dividend: 12 x 12 product
    localparam int WIDX_W     = NUM_W + 1;    // product plus column word offset
    localparam int CFG_IDX_W  = 3;

    // Parameter defaults
    localparam int STORE_WORDS_DEF = 2097152;
    localparam int MAX_DIM_DEF     = 2048;

    // Register reset values
    localparam logic [DIM_W-1:0]    IN_WIDTH_RST   = DIM_W'(640);
    localparam logic [DIM_W-1:0]    IN_HEIGHT_RST  = DIM_W'(480);
    localparam logic [STRIDE_W-1:0] IN_STRIDE_RST  = '0;
    localparam logic [DIM_W-1:0]    OUT_WIDTH_RST  = DIM_W'(640);
    localparam logic [DIM_W-1:0]    OUT_HEIGHT_RST = DIM_W'(480);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IN_WIDTH   = 3'd0,
        CFG_IN_HEIGHT  = 3'd1,
        CFG_IN_STRIDE  = 3'd2,
        CFG_OUT_WIDTH  = 3'd3,
        CFG_OUT_HEIGHT = 3'd4
    } cfg_index_t;

    localparam logic OP_WRITE     = 1'b0;
    localparam logic OP_READ      = 1'b1;
    localparam logic PLANE_LUMA   = 1'b0;
    localparam logic PLANE_CHROMA = 1'b1;

    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_RANGE      = 2'd1;
    localparam logic [1:0] ERR_PAST_STORE = 2'd2;

    typedef struct packed {
        logic                operation;
        logic [WADDR_W-1:0]  word_address;
        logic [WORD_W-1:0]   word_data;
        logic                plane;
        logic [COORD_W-1:0]  out_x;
        logic [COORD_W-1:0]  out_y;
    } in_item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_a;
        logic [SAMPLE_W-1:0] sample_b;
        logic [1:0]          error;
    } out_item_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] numerator;
        logic [DIM_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIM_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

### hdl/y2nv_divider.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
// Caller guarantees numerator < divisor * 2**DIM_W, so the quotient fits DIM_W bits
// and the upper numerator half seeds the remainder directly.
module y2nv_divider (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire y2nv_pkg::div_req_t  req,
    output y2nv_pkg::div_rsp_t       rsp
);
    import y2nv_pkg::*;

    localparam int STEPS = DIM_W;
    localparam int CNT_W = $clog2(STEPS);

    logic             busy_reg;
    logic [CNT_W-1:0] count_reg;
    logic [DIM_W-1:0] rem_reg;
    logic [DIM_W-1:0] work_reg;     // numerator bits out, quotient bits in
    logic [DIM_W-1:0] divisor_reg;

    logic [DIM_W:0]   shifted;
    logic [DIM_W:0]   diff;
    logic             fits;
    logic             last;
    logic [DIM_W-1:0] rem_next;
    logic [DIM_W-1:0] work_next;

    always_comb
    begin
        shifted   = {rem_reg, work_reg[DIM_W-1]};
        diff      = shifted - {1'b0, divisor_reg};
        fits      = shifted >= {1'b0, divisor_reg};
        rem_next  = fits ? diff[DIM_W-1:0] : shifted[DIM_W-1:0];
        work_next = {work_reg[DIM_W-2:0], fits};
        last      = count_reg == CNT_W'(STEPS - 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (req.start)
        begin
            busy_reg  <= 1'b1;
            count_reg <= '0;
        end
        else if (busy_reg)
        begin
            count_reg <= count_reg + 1'b1;
            if (last)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg     <= req.numerator[NUM_W-1:DIM_W];
            work_reg    <= req.numerator[DIM_W-1:0];
            divisor_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            work_reg <= work_next;
        end
    end

    assign rsp.done     = busy_reg && last;
    assign rsp.quotient = work_next;

endmodule

`default_nettype wire

### hdl/yuyv_to_nv12_nearest_scaler.sv
`default_nettype none

// Nearest-neighbor YUYV 4:2:2 to NV12 scaler over an on-chip frame store of
// STORE_WORDS 32-bit words (byte0 Y0, byte1 U, byte2 Y1, byte3 V). A write beat
// stores one word and returns nothing; writes past the store are dropped. A
// read beat asks for one luma sample or one U/V pair of the out_width x
// out_height output and returns exactly one result beat. A read runs two
// divisions on one shared restoring divider (row, then column), three passes
// through one shared 12x12 multiplier and a registered store read; the next
// beat is taken only once the sequencer is back in idle. Out-of-range
// coordinates skip the arithmetic: the sequencer goes straight to its result
// state and registers the error 1 result beat. A result stalled in the output
// register holds off the next result and so the input as well. A source word
// past the store gives error 2. Errors return zero samples. The store has no
// reset: reading a word never written returns whatever it holds. Program the
// registers only while no read is in flight.
module yuyv_to_nv12_nearest_scaler #(
    parameter int STORE_WORDS = y2nv_pkg::STORE_WORDS_DEF,
    parameter int MAX_DIM     = y2nv_pkg::MAX_DIM_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration
    input  wire logic                            cfg_write,
    input  wire logic [y2nv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [y2nv_pkg::DIM_W-1:0]      cfg_data,
    // request channel
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire y2nv_pkg::in_item_t              in_data,
    // result channel
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output y2nv_pkg::out_item_t                  out_data
);
    import y2nv_pkg::*;

    localparam int ADDR_W = $clog2(STORE_WORDS);

    // One-hot sequencer
    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_MUL_Y  = 8'b0000_0010,   // row product into divider
        S_DIV_Y  = 8'b0000_0100,
        S_MUL_X  = 8'b0000_1000,   // column product into divider
        S_DIV_X  = 8'b0001_0000,
        S_ADDR   = 8'b0010_0000,   // sy * stride + sx / 2
        S_READ   = 8'b0100_0000,   // bound check, store read
        S_RESULT = 8'b1000_0000    // wait for output slot
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Configuration registers
    logic [DIM_W-1:0]    in_width_reg;
    logic [DIM_W-1:0]    in_height_reg;
    logic [STRIDE_W-1:0] in_stride_reg;
    logic [DIM_W-1:0]    out_width_reg;
    logic [DIM_W-1:0]    out_height_reg;

    // Per-read working registers
    logic                plane_reg;
    logic [COORD_W-1:0]  x_reg;
    logic [COORD_W-1:0]  y_reg;
    logic [DIM_W-1:0]    sy_reg;
    logic [DIM_W-1:0]    sx_reg;
    logic [WIDX_W-1:0]   widx_reg;
    logic [1:0]          err_reg;
    logic [WORD_W-1:0]   rd_data_reg;

    logic                out_valid_reg;
    out_item_t           out_data_reg;

    logic [WORD_W-1:0]   frame_store [STORE_WORDS];

    logic                in_accept;
    logic                range_err;
    logic                store_wr;
    logic                store_rd;
    logic                past_store;
    logic                out_free;
    logic [DIM_W-1:0]    stride;
    logic [DIM_W:0]      width_round;
    logic [DIM_W-1:0]    mul_a;
    logic [DIM_W-1:0]    mul_b;
    logic [NUM_W-1:0]    mul_prod;
    div_req_t            div_req;
    div_rsp_t            div_rsp;
    out_item_t           result;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        clamp_dim = (32'(v) > MAX_DIM) ? DIM_W'(MAX_DIM) : v;
    endfunction

    assign in_stall  = state_reg != S_IDLE;
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // Range test on the incoming beat
    always_comb
    begin
        if (in_data.plane == PLANE_LUMA)
        begin
            range_err = ({1'b0, in_data.out_x} >= out_width_reg)
                     || ({1'b0, in_data.out_y} >= out_height_reg);
        end
        else
        begin
            range_err = in_data.out_x[0]
                     || ({1'b0, in_data.out_x} >= out_width_reg)
                     || ({1'b0, in_data.out_y} >= (out_height_reg >> 1));
        end
    end

    // Zero stride: ceil(width / 2)
    assign width_round = {1'b0, in_width_reg} + 1'b1;
    assign stride      = (in_stride_reg != '0) ? {1'b0, in_stride_reg}
                                               : width_round[DIM_W:1];

    // Shared multiplier
    always_comb
    begin
        unique case (state_reg)
            S_MUL_Y:
            begin
                mul_a = (plane_reg == PLANE_CHROMA) ? {y_reg, 1'b0} : {1'b0, y_reg};
                mul_b = in_height_reg;
            end
            S_MUL_X:
            begin
                mul_a = {1'b0, x_reg};
                mul_b = in_width_reg;
            end
            default:
            begin
                mul_a = sy_reg;
                mul_b = stride;
            end
        endcase
    end

    assign mul_prod = mul_a * mul_b;

    // Product goes straight into the divider's registers
    assign div_req.start     = (state_reg == S_MUL_Y) || (state_reg == S_MUL_X);
    assign div_req.numerator = mul_prod;
    assign div_req.divisor   = (state_reg == S_MUL_Y) ? out_height_reg : out_width_reg;

    y2nv_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign past_store = 32'(widx_reg) >= STORE_WORDS;
    assign store_rd   = (state_reg == S_READ) && !past_store;
    assign store_wr   = in_accept && (in_data.operation == OP_WRITE)
                     && (32'(in_data.word_address) < STORE_WORDS);

    // Frame store, registered read
    always_ff @(posedge clk)
    begin
        if (store_wr)
        begin
            frame_store[ADDR_W'(in_data.word_address)] <= in_data.word_data;
        end
        if (store_rd)
        begin
            rd_data_reg <= frame_store[widx_reg[ADDR_W-1:0]];
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept && (in_data.operation == OP_READ))
                begin
                    state_next = range_err ? S_RESULT : S_MUL_Y;
                end
            end
            S_MUL_Y:  state_next = S_DIV_Y;
            S_DIV_Y:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_MUL_X;
                end
            end
            S_MUL_X:  state_next = S_DIV_X;
            S_DIV_X:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_ADDR;
                end
            end
            S_ADDR:   state_next = S_READ;
            S_READ:   state_next = S_RESULT;
            S_RESULT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration writes; widths and heights saturate at MAX_DIM
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_width_reg   <= IN_WIDTH_RST;
            in_height_reg  <= IN_HEIGHT_RST;
            in_stride_reg  <= IN_STRIDE_RST;
            out_width_reg  <= OUT_WIDTH_RST;
            out_height_reg <= OUT_HEIGHT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_IN_WIDTH:   in_width_reg   <= clamp_dim(cfg_data);
                CFG_IN_HEIGHT:  in_height_reg  <= clamp_dim(cfg_data);
                CFG_IN_STRIDE:  in_stride_reg  <= cfg_data[STRIDE_W-1:0];
                CFG_OUT_WIDTH:  out_width_reg  <= clamp_dim(cfg_data);
                CFG_OUT_HEIGHT: out_height_reg <= clamp_dim(cfg_data);
                default:        ;
            endcase
        end
    end

    // Working datapath
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            plane_reg <= in_data.plane;
            x_reg     <= in_data.out_x;
            y_reg     <= in_data.out_y;
            err_reg   <= range_err ? ERR_RANGE : ERR_NONE;
        end
        if ((state_reg == S_DIV_Y) && div_rsp.done)
        begin
            // chroma rows come from even source lines
            sy_reg <= (plane_reg == PLANE_CHROMA) ? {div_rsp.quotient[DIM_W-1:1], 1'b0}
                                                  : div_rsp.quotient;
        end
        if ((state_reg == S_DIV_X) && div_rsp.done)
        begin
            sx_reg <= (plane_reg == PLANE_CHROMA) ? {div_rsp.quotient[DIM_W-1:1], 1'b0}
                                                  : div_rsp.quotient;
        end
        if (state_reg == S_ADDR)
        begin
            widx_reg <= WIDX_W'(mul_prod) + WIDX_W'(sx_reg[DIM_W-1:1]);
        end
        if (state_reg == S_READ)
        begin
            err_reg <= past_store ? ERR_PAST_STORE : ERR_NONE;
        end
    end

    // Result formatting
    always_comb
    begin
        result.error    = err_reg;
        result.sample_a = '0;
        result.sample_b = '0;
        if (err_reg == ERR_NONE)
        begin
            if (plane_reg == PLANE_LUMA)
            begin
                result.sample_a = sx_reg[0] ? rd_data_reg[23:16] : rd_data_reg[7:0];
            end
            else
            begin
                result.sample_a = rd_data_reg[15:8];
                result.sample_b = rd_data_reg[31:24];
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == S_RESULT) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_RESULT) && out_free)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire
